>>> rtl/gha_pkg.sv
`timescale 1ns / 1ps
// gha_pkg: operation and status codes plus the stack command struct
// for the generational handle allocator. No dependencies.
package gha_pkg;

	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_CHECK   = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	// free stack request from the execute stage
	typedef struct packed {
		logic push;
		logic pop;
	} stk_cmd_t;

endpackage

>>> rtl/gha_free_stack.sv
`timescale 1ns / 1ps
// gha_free_stack: LIFO of freed slots, each entry holding index and next version.
// Uses gha_pkg (stk_cmd_t). Top entry is registered and presented in the cycle after any push/pop.
module gha_free_stack import gha_pkg::*; #(
	parameter int DEPTH = 1024,
	parameter int VW    = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  stk_cmd_t                       cmd,
	input  logic [$clog2(DEPTH)-1:0]       push_index,
	input  logic [VW-1:0]                  push_version,
	output logic [$clog2(DEPTH)-1:0]       top_index,
	output logic [VW-1:0]                  top_version,
	output logic [$clog2(DEPTH+1)-1:0]     count
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [IW+VW-1:0] mem [DEPTH];
	logic [CW-1:0]    fc_q;
	logic [CW-1:0]    fc_next;
	logic [IW-1:0]    wr_addr;
	logic [IW-1:0]    rd_addr;
	logic [IW+VW-1:0] wr_data;
	logic [IW+VW-1:0] rd_data_q;
	logic [IW+VW-1:0] byp_data_q;
	logic             byp_q;

	always_comb begin
		fc_next = fc_q + CW'(cmd.push) - CW'(cmd.pop);
		wr_addr = fc_q[IW-1:0];
		// entry just below the new count becomes the top; garbage when empty, never popped
		rd_addr = IW'(fc_next - CW'(1));
		wr_data = {push_index, push_version};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q <= '0;
		end else begin
			fc_q <= fc_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q  <= mem[rd_addr];
		// a push lands on the entry being read: take the new data
		byp_q      <= cmd.push && (wr_addr == rd_addr);
		byp_data_q <= wr_data;
	end

	assign {top_index, top_version} = byp_q ? byp_data_q : rd_data_q;
	assign count = fc_q;

endmodule

>>> rtl/generational_handle_allocator_unit.sv
`timescale 1ns / 1ps
// generational_handle_allocator_unit: top level, slot table and execute stage.
// Uses gha_pkg and gha_free_stack.
//
// Usage:
//   Request channel: drive op, handle_index and handle_version with start high;
//   a beat is taken at every rising edge with start high and busy low. busy is
//   never raised, so one request can be issued every cycle.
//   Result channel: done is high for exactly one cycle with status, out_index,
//   out_version, handle_live and live_count. The receiver cannot stall; every
//   result must be captured in that cycle.
//   An accepted request passes through the execute register and then the result
//   register before done rises. Throughput is one request per cycle, bound by
//   the single write port of the slot table and of the free stack; back-to-back
//   hazards on both are covered by bypass paths.
//   Reset: clears the free count and the never-used slot mark, so the table is
//   empty and no handle is live. Table contents need no clearing: an entry is
//   only read once its slot has been handed out.
module generational_handle_allocator_unit import gha_pkg::*; #(
	parameter int MAX_SLOTS    = 1024,
	parameter int VERSION_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         op,
	input  logic [$clog2(MAX_SLOTS)-1:0]       handle_index,
	input  logic [VERSION_BITS-1:0]            handle_version,
	output logic                               done,
	output logic [1:0]                         status,
	output logic [$clog2(MAX_SLOTS)-1:0]       out_index,
	output logic [VERSION_BITS-1:0]            out_version,
	output logic                               handle_live,
	output logic [$clog2(MAX_SLOTS+1)-1:0]     live_count
);

	localparam int IW = $clog2(MAX_SLOTS);
	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam int VW = VERSION_BITS;

	// slot table entry: {live, version}
	logic [VW:0]     slot_mem [MAX_SLOTS];

	logic            valid_s1;
	logic [1:0]      op_s1;
	logic [IW-1:0]   idx_s1;
	logic [VW-1:0]   ver_s1;
	logic [VW:0]     slot_rd_s1;
	logic [VW:0]     slot_byp_data_s1;
	logic            slot_byp_s1;

	logic [CW-1:0]   hw_q;
	logic [CW-1:0]   hw_next;
	logic [CW-1:0]   fc;
	logic [CW-1:0]   fc_next;

	stk_cmd_t        stk_cmd;
	logic [IW-1:0]   top_index;
	logic [VW-1:0]   top_version;

	logic [VW:0]     slot_cur;
	logic            hit;
	logic            slot_we;
	logic [IW-1:0]   slot_waddr;
	logic [VW:0]     slot_wdata;

	logic [1:0]      status_d;
	logic [IW-1:0]   oidx_d;
	logic [VW-1:0]   over_d;
	logic            live_d;

	logic            done_q;
	logic [1:0]      status_q;
	logic [IW-1:0]   out_index_q;
	logic [VW-1:0]   out_version_q;
	logic            handle_live_q;
	logic [CW-1:0]   live_count_q;

	assign busy = 1'b0;

	gha_free_stack #(
		.DEPTH (MAX_SLOTS),
		.VW    (VW)
	) u_stack (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (stk_cmd),
		.push_index   (idx_s1),
		.push_version (slot_wdata[VW-1:0]),
		.top_index    (top_index),
		.top_version  (top_version),
		.count        (fc)
	);

	// input register; table read runs in parallel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		op_s1            <= op;
		idx_s1           <= handle_index;
		ver_s1           <= handle_version;
		slot_rd_s1       <= slot_mem[handle_index];
		slot_byp_s1      <= slot_we && (slot_waddr == handle_index);
		slot_byp_data_s1 <= slot_wdata;
		if (slot_we) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
	end

	// execute
	always_comb begin
		slot_cur = slot_byp_s1 ? slot_byp_data_s1 : slot_rd_s1;
		hit = (CW'(idx_s1) < hw_q) && slot_cur[VW] && (slot_cur[VW-1:0] == ver_s1);

		stk_cmd    = '0;
		slot_we    = 1'b0;
		slot_waddr = idx_s1;
		slot_wdata = {1'b0, slot_cur[VW-1:0] + VW'(1)};
		hw_next    = hw_q;
		status_d   = ST_OK;
		oidx_d     = '0;
		over_d     = '0;
		live_d     = 1'b0;

		if (valid_s1) begin
			case (op_s1)
				OP_ALLOC: begin
					if (fc != '0) begin
						stk_cmd.pop = 1'b1;
						slot_we     = 1'b1;
						slot_waddr  = top_index;
						slot_wdata  = {1'b1, top_version};
						oidx_d      = top_index;
						over_d      = top_version;
						live_d      = 1'b1;
					end else if (hw_q < CW'(MAX_SLOTS)) begin
						slot_we    = 1'b1;
						slot_waddr = hw_q[IW-1:0];
						slot_wdata = {1'b1, {VW{1'b0}}};
						hw_next    = hw_q + CW'(1);
						oidx_d     = hw_q[IW-1:0];
						live_d     = 1'b1;
					end else begin
						status_d = ST_FULL;
					end
				end
				OP_RELEASE: begin
					if (hit) begin
						// bump version, mark free, push with the bumped version
						stk_cmd.push = 1'b1;
						slot_we      = 1'b1;
						live_d       = 1'b1;
					end else begin
						status_d = ST_INVALID;
					end
				end
				OP_CHECK: begin
					live_d = hit;
				end
				default: begin
				end
			endcase
		end

		fc_next = fc + CW'(stk_cmd.push) - CW'(stk_cmd.pop);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q   <= '0;
			done_q <= 1'b0;
		end else begin
			hw_q   <= hw_next;
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		status_q      <= status_d;
		out_index_q   <= oidx_d;
		out_version_q <= over_d;
		handle_live_q <= live_d;
		live_count_q  <= hw_next - fc_next;
	end

	assign done        = done_q;
	assign status      = status_q;
	assign out_index   = out_index_q;
	assign out_version = out_version_q;
	assign handle_live = handle_live_q;
	assign live_count  = live_count_q;

	// free slots can never outnumber slots handed out
	a_free_le_hw: assert property (@(posedge clk) disable iff (!arst_n)
		fc <= hw_q)
		else $error("free count exceeds high water mark");

	// one result beat per executed request
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done_q)
		else $error("executed request produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> !done_q)
		else $error("result without request");

	// table full only when every slot is handed out and none is free
	a_full_real: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (status_q == ST_FULL)) |->
			((live_count_q == CW'(MAX_SLOTS)) && !handle_live_q))
		else $error("full reported with slots available");

	// the stack never pops and pushes in the same beat
	a_stack_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		!(stk_cmd.push && stk_cmd.pop))
		else $error("simultaneous push and pop");

endmodule
